// ===== rtl/pmtc_pkg.sv =====
// Package for the probability-map threshold colorizer.
// Holds the fixed-point constants, the pipeline depths and the root table functions.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package pmtc_pkg;

    // Default width of the probability fraction.
    localparam int PROB_BITS_DEF = 16;

    // Width of the threshold register and its value after reset.
    localparam int          THR_W        = 16;
    localparam logic [15:0] THRESH_RESET = 16'd32768;

    // log2(100) in unsigned Q28, and the scaling of the exponent quotient.
    localparam int          LOG2_W       = 31;
    localparam logic [30:0] LOG2_100_Q28 = 31'd1783446566;
    localparam int          NUM_SHIFT    = 12;

    // The exponent x is Q16 with three integer bits; x >= 8 saturates.
    localparam int DIV_STEPS  = 19;
    localparam int FRAC_BITS  = 16;
    localparam int ROOT_STEPS = 16;

    // Q30 mantissa of 2^-f, and one in that format.
    localparam int          MANT_W  = 31;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Register stages: product, overflow check, quotient bits, root products, output.
    localparam int NUM_STAGES = 2 + DIV_STEPS + ROOT_STEPS + 1;

    // Per-item values that ride along the pipeline beside the arithmetic.
    typedef struct packed {
        logic       mask;
        logic       le;
        logic [7:0] gray;
    } t_side;

    // Integer square root, bit by bit, evaluated only at elaboration.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-2^-j) in Q30, built by repeated square roots starting from one half.
    function automatic logic [29:0] root_q30(input int j);
        logic [63:0] r;
        r = 64'd1 << 29;
        for (int k = 1; k <= ROOT_STEPS; k++) begin
            if (k <= j) begin
                r = isqrt64(r << 30);
            end
        end
        return r[29:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/prob_map_threshold_colorize_unit.sv =====
// Top level of the probability-map threshold colorizer: one fully pipelined datapath.
// Uses pmtc_pkg for constants, the side-band struct and the elaboration-time root table.
// No submodules.
`default_nettype none

// The unit takes one pixel item per clock and returns one result item per item, in order.
// Each item carries a Q0.PROB_BITS change probability, a mask bit and a gray byte; the
// result is a binarized RGB triple and a graded RGB triple. The datapath has 38 register
// stages: one stage forms log2(100)*prob, one checks the exponent for saturation,
// nineteen stages each resolve one bit of the quotient by the divisor 1 - threshold,
// sixteen stages each apply one root-table product to build 2^-f, and the last stage
// scales by 255, shifts by the integer part and registers the outputs.
// The whole pipeline advances together whenever the output register is empty or being
// taken, so the sustained rate is one item per cycle while i_ready stays high; when the
// output stalls, o_ready drops in the same cycle and no item is dropped or repeated.
// The threshold register is written with i_cfg_we and takes effect for items accepted
// afterwards; it should be written only while the pipeline is empty.
module prob_map_threshold_colorize_unit #(
    parameter int PROB_BITS = pmtc_pkg::PROB_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write.
    input  wire logic                 i_cfg_we,
    input  wire logic [15:0]          i_cfg_wdata,
    // Input item channel.
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [PROB_BITS-1:0] i_prob,
    input  wire logic                 i_mask,
    input  wire logic [7:0]           i_gray,
    // Result item channel.
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [7:0]                o_bin_red,
    output logic [7:0]                o_bin_green,
    output logic [7:0]                o_bin_blue,
    output logic [7:0]                o_map_red,
    output logic [7:0]                o_map_green,
    output logic [7:0]                o_map_blue
);

    localparam int NST    = pmtc_pkg::NUM_STAGES;
    localparam int DSTEPS = pmtc_pkg::DIV_STEPS;
    localparam int RSTEPS = pmtc_pkg::ROOT_STEPS;
    localparam int MW     = pmtc_pkg::MANT_W;
    localparam int PROD_W = PROB_BITS + pmtc_pkg::LOG2_W;
    // Dividend after the 2^12 scale is folded out of the divisor.
    localparam int NUMW   = PROD_W - pmtc_pkg::NUM_SHIFT;
    localparam int DW     = PROB_BITS + 1;
    localparam int FB     = pmtc_pkg::FRAC_BITS;
    localparam int SCW    = MW + 8;

    // Global advance: every stage moves when the output register can accept.
    logic adv;

    // Configuration register.
    logic [15:0] r_threshold;

    // Valid bits, one per stage; bit 0 is the product stage, the top bit the output.
    logic [NST-1:0] r_vld;

    // Side-band values for every stage that feeds another stage.
    pmtc_pkg::t_side r_side [NST-1];

    // Stage A: dividend and divisor.
    logic [NUMW-1:0]      r_a_num;
    logic [DW-1:0]        r_a_d;
    // Stage B: dividend, divisor and saturation flag.
    logic [NUMW-1:0]      r_b_num;
    logic [DW-1:0]        r_b_d;
    logic                 r_b_ovf;

    // Quotient stages.
    logic [NUMW-1:0]      r_dv_rem [DSTEPS];
    logic [DSTEPS-1:0]    r_dv_q   [DSTEPS];
    logic [DW-1:0]        r_dv_d   [DSTEPS];
    logic                 r_dv_ovf [DSTEPS];

    // Root product stages.
    logic [MW-1:0]        r_rt_r   [RSTEPS];
    logic [DSTEPS-1:0]    r_rt_x   [RSTEPS];
    logic                 r_rt_ovf [RSTEPS];

    // Output registers.
    logic [7:0] r_bin_red;
    logic [7:0] r_bin_green;
    logic [7:0] r_bin_blue;
    logic [7:0] r_map_red;
    logic [7:0] r_map_green;
    logic [7:0] r_map_blue;

    // Next values of the front stages.
    logic [PROB_BITS-1:0] n_thr;
    logic [PROD_W-1:0]    n_prod;
    logic [DW-1:0]        n_d;
    logic [NUMW:0]        n_lim;
    logic                 n_ovf;

    // Next values of the output stage.
    logic [MW-1:0]        n_fin_r;
    logic [DSTEPS-FB-1:0] n_fin_x;
    logic [SCW-1:0]       n_scaled;
    logic [SCW-1:0]       n_shifted;
    logic [7:0]           n_grade;
    pmtc_pkg::t_side      n_fin_side;

    assign adv     = ~r_vld[NST-1] | i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NST-1];

    // The register is 16 bits wide; only PROB_BITS of it form the threshold.
    assign n_thr  = PROB_BITS'(r_threshold);
    assign n_prod = PROD_W'(i_prob) * PROD_W'(pmtc_pkg::LOG2_100_Q28);
    // One minus the threshold, never zero since the threshold is a pure fraction.
    assign n_d    = {1'b1, {PROB_BITS{1'b0}}} - {1'b0, n_thr};

    // The exponent saturates once the quotient reaches 8.0 in Q16.
    assign n_lim = (NUMW + 1)'(r_a_d) << DSTEPS;
    assign n_ovf = {1'b0, r_a_num} >= n_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= pmtc_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= '{mask: i_mask, le: (i_prob <= n_thr), gray: i_gray};
            for (int s = 1; s < NST - 1; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_a_num <= n_prod[PROD_W-1:pmtc_pkg::NUM_SHIFT];
            r_a_d   <= n_d;
            r_b_num <= r_a_num;
            r_b_d   <= r_a_d;
            r_b_ovf <= n_ovf;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar gi = 0; gi < DSTEPS; gi++) begin : g_div
        localparam int K = DSTEPS - 1 - gi;
        logic [NUMW-1:0]   n_rem_in;
        logic [DSTEPS-1:0] n_q_in;
        logic [DW-1:0]     n_d_in;
        logic              n_ovf_in;
        logic [NUMW-1:0]   n_dsh;

        if (gi == 0) begin : g_first
            assign n_rem_in = r_b_num;
            assign n_q_in   = '0;
            assign n_d_in   = r_b_d;
            assign n_ovf_in = r_b_ovf;
        end else begin : g_next
            assign n_rem_in = r_dv_rem[gi-1];
            assign n_q_in   = r_dv_q[gi-1];
            assign n_d_in   = r_dv_d[gi-1];
            assign n_ovf_in = r_dv_ovf[gi-1];
        end

        assign n_dsh = NUMW'(n_d_in) << K;

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (n_rem_in >= n_dsh) begin
                    r_dv_rem[gi] <= n_rem_in - n_dsh;
                    r_dv_q[gi]   <= {n_q_in[DSTEPS-2:0], 1'b1};
                end else begin
                    r_dv_rem[gi] <= n_rem_in;
                    r_dv_q[gi]   <= {n_q_in[DSTEPS-2:0], 1'b0};
                end
                r_dv_d[gi]   <= n_d_in;
                r_dv_ovf[gi] <= n_ovf_in;
            end
        end
    end

    // 2^-f as a chain of truncated Q30 products, one fraction bit per stage.
    for (genvar gj = 0; gj < RSTEPS; gj++) begin : g_root
        localparam logic [29:0] RC = pmtc_pkg::root_q30(gj + 1);
        logic [MW-1:0]     n_r_in;
        logic [DSTEPS-1:0] n_x_in;
        logic              n_ovf_in;
        logic [2*MW-2:0]   n_mul;

        if (gj == 0) begin : g_first
            assign n_r_in   = pmtc_pkg::ONE_Q30;
            assign n_x_in   = r_dv_q[DSTEPS-1];
            assign n_ovf_in = r_dv_ovf[DSTEPS-1];
        end else begin : g_next
            assign n_r_in   = r_rt_r[gj-1];
            assign n_x_in   = r_rt_x[gj-1];
            assign n_ovf_in = r_rt_ovf[gj-1];
        end

        assign n_mul = (2*MW-1)'(n_r_in) * (2*MW-1)'(RC);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (n_x_in[FB-1-gj]) begin
                    r_rt_r[gj] <= n_mul[MW+29:30];
                end else begin
                    r_rt_r[gj] <= n_r_in;
                end
                r_rt_x[gj]   <= n_x_in;
                r_rt_ovf[gj] <= n_ovf_in;
            end
        end
    end

    // Scale by 255, shift by the integer part of the exponent, drop the Q30 fraction.
    always_comb begin
        n_fin_r    = r_rt_r[RSTEPS-1];
        n_fin_x    = r_rt_x[RSTEPS-1][DSTEPS-1:FB];
        n_fin_side = r_side[NST-2];
        n_scaled   = SCW'(n_fin_r) * SCW'(9'd255);
        n_shifted  = n_scaled >> n_fin_x;
        if (r_rt_ovf[RSTEPS-1]) begin
            n_grade = 8'd0;
        end else if (n_shifted[SCW-1:38] != '0) begin
            n_grade = 8'd255;
        end else begin
            n_grade = n_shifted[37:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (!n_fin_side.mask) begin
                r_bin_red   <= 8'd0;
                r_bin_green <= 8'd0;
                r_bin_blue  <= 8'd0;
                r_map_red   <= 8'd0;
                r_map_green <= 8'd0;
                r_map_blue  <= 8'd0;
            end else begin
                r_bin_red   <= n_fin_side.le ? 8'd255 : n_fin_side.gray;
                r_bin_green <= n_fin_side.gray;
                r_bin_blue  <= n_fin_side.gray;
                r_map_red   <= n_fin_side.le ? n_grade : n_fin_side.gray;
                r_map_green <= n_fin_side.gray;
                r_map_blue  <= n_fin_side.gray;
            end
        end
    end

    assign o_bin_red   = r_bin_red;
    assign o_bin_green = r_bin_green;
    assign o_bin_blue  = r_bin_blue;
    assign o_map_red   = r_map_red;
    assign o_map_green = r_map_green;
    assign o_map_blue  = r_map_blue;

`ifndef SYNTHESIS
    a_rst_empty : assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("pipeline not empty after reset");

    a_stall_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input accepted while the output is stalled");

    a_enter_stage : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted item missing from the first stage");

    a_gray_channels : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bin_green == o_map_green && o_bin_blue == o_map_blue
                     && o_bin_green == o_bin_blue))
        else $error("green and blue channels disagree");

    a_over_threshold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bin_red != 8'd255 |-> o_map_red == o_bin_red)
        else $error("graded red differs from gray above the threshold");
`endif

endmodule

`default_nettype wire
